>>> hdl/lcgms_pkg.sv
// Shared constants, codes and types of the gate mask sequencer.
`timescale 1ns / 1ps

package lcgms_pkg;

  // Number of light outputs in the chain; only the first GateW have a gate bit.
  localparam int NumOutputs = 8;
  localparam int GateW      = 8;
  localparam int RateW      = 10;
  localparam int CntW       = 12;
  localparam int MaskW      = 16;
  localparam int ModeW      = 4;
  localparam int RunW       = 4;
  localparam int AddrW      = 3;
  localparam int DataW      = 32;

  // The counter clears once it reaches this value.
  localparam logic [CntW-1:0] StepLimit = CntW'(2048);
  localparam logic [RunW-1:0] TripleRun = RunW'(3);
  localparam logic [RunW-1:0] FullRun   = RunW'(NumOutputs);

  typedef enum logic [ModeW-1:0] {
    PatDisabled = 4'd0,
    PatSingle   = 4'd1,
    PatGrow     = 4'd2,
    PatPass     = 4'd3,
    PatDouble   = 4'd4
  } pattern_e;

  // Register word index, taken from the word address bit of paddr.
  typedef enum logic {
    RegPatternMode = 1'b0,
    RegTriplify    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             triplify;
    logic [MaskW-1:0] mask;
    logic             rising;
  } step_req_t;

  typedef struct packed {
    logic [MaskW-1:0] mask;
    logic             rising;
    logic [GateW-1:0] gates;
  } step_rsp_t;

endpackage

>>> hdl/led_chaser_gate_mask_sequencer.sv
// Top level of the gate mask sequencer: request channels, register port and state.
`timescale 1ns / 1ps

// Channel       | Direction | Handshake                  | Payload
// --------------+-----------+----------------------------+------------------------
// tick request  | in        | in_valid_i / in_ready_o    | rate_value_i (10 bits)
// gate result   | out       | out_valid_o / out_ready_i  | gate_bits_o, stepped_o
// registers     | in/out    | psel, penable, pwrite      | paddr, pwdata, prdata
//
// A request is captured in the input register at the edge that accepts it. It then
// passes through the counter and mask step into the result register once that
// register is empty or being emptied, and its result is offered until it is taken.
// A new request can be taken on every cycle, so the sustained rate is one
// request per cycle while the result side keeps up. When the result register is full
// and not being taken, the input register holds and in_ready_o falls once it is full.
// Reset clears the counter and gates, sets the mask to its base of one and the bounce
// phase to rising, and returns both registers to zero.
module led_chaser_gate_mask_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lcgms_pkg::RateW-1:0]   rate_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lcgms_pkg::GateW-1:0]   gate_bits_o,
  output logic                          stepped_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcgms_pkg::AddrW-1:0]   paddr,
  input  logic [lcgms_pkg::DataW-1:0]   pwdata,
  output logic [lcgms_pkg::DataW-1:0]   prdata,
  output logic                          pready
);

  // Input stage.
  logic                          in_vld_q;
  logic [lcgms_pkg::RateW-1:0]   rate_q;
  // Result stage.
  logic                          out_vld_q;
  logic [lcgms_pkg::GateW-1:0]   gate_q, gate_d;
  logic                          stepped_q, stepped_d;
  // Sequencer state.
  logic [lcgms_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [lcgms_pkg::MaskW-1:0]   mask_q, mask_d;
  logic                          rising_q, rising_d;
  // Registers.
  logic [lcgms_pkg::ModeW-1:0]   mode_q;
  logic                          trip_q;

  logic                          adv;
  logic                          cfg_wr;
  logic [lcgms_pkg::CntW-1:0]    cnt_sum;
  logic                          step_hit;
  lcgms_pkg::step_req_t          step_req;
  lcgms_pkg::step_rsp_t          step_rsp;

  // The held request moves on when the result register is empty or being emptied.
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign cfg_wr     = psel && penable && pwrite && pready;

  // The counter never holds more than the limit minus one, so a quarter of the
  // rate added to it cannot overflow twelve bits.
  assign cnt_sum  = cnt_q + lcgms_pkg::CntW'(rate_q >> 2);
  assign step_hit = (lcgms_pkg::pattern_e'(mode_q) != lcgms_pkg::PatDisabled) &&
                    (cnt_sum >= lcgms_pkg::StepLimit);

  assign step_req.mode     = mode_q;
  assign step_req.triplify = trip_q;
  assign step_req.mask     = mask_q;
  assign step_req.rising   = rising_q;

  lcgms_mask_step u_step (
    .req_i (step_req),
    .rsp_o (step_rsp)
  );

  always_comb begin
    cnt_d     = cnt_q;
    mask_d    = mask_q;
    rising_d  = rising_q;
    gate_d    = gate_q;
    stepped_d = stepped_q;
    if (adv) begin
      stepped_d = step_hit;
      if (lcgms_pkg::pattern_e'(mode_q) != lcgms_pkg::PatDisabled) begin
        cnt_d = cnt_sum;
      end
      if (step_hit) begin
        cnt_d    = '0;
        mask_d   = step_rsp.mask;
        rising_d = step_rsp.rising;
        gate_d   = step_rsp.gates;
      end
    end
    // A register write restarts the pattern from its base.
    if (cfg_wr) begin
      mask_d   = lcgms_pkg::MaskW'(1);
      rising_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      mask_q    <= lcgms_pkg::MaskW'(1);
      rising_q  <= 1'b1;
      gate_q    <= '0;
      stepped_q <= 1'b0;
      mode_q    <= '0;
      trip_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      cnt_q     <= cnt_d;
      mask_q    <= mask_d;
      rising_q  <= rising_d;
      gate_q    <= gate_d;
      stepped_q <= stepped_d;
      if (cfg_wr) begin
        unique case (lcgms_pkg::reg_idx_e'(paddr[2]))
          lcgms_pkg::RegPatternMode: mode_q <= pwdata[lcgms_pkg::ModeW-1:0];
          lcgms_pkg::RegTriplify:    trip_q <= pwdata[0];
          default:                   mode_q <= mode_q;
        endcase
      end
    end
  end

  // The rate payload needs no reset; it is only read while in_vld_q is set.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rate_q <= rate_value_i;
    end
  end

  always_comb begin
    unique case (lcgms_pkg::reg_idx_e'(paddr[2]))
      lcgms_pkg::RegPatternMode: prdata = lcgms_pkg::DataW'(mode_q);
      lcgms_pkg::RegTriplify:    prdata = lcgms_pkg::DataW'(trip_q);
      default:                   prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign out_valid_o = out_vld_q;
  assign gate_bits_o = gate_q;
  assign stepped_o   = stepped_q;

  // The counter always rests below the step limit.
  a_cnt_below_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < lcgms_pkg::StepLimit)
    else $error("step counter reached the limit without clearing");

  // A step clears the counter and is reported with the result.
  a_step_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && step_hit |=> cnt_q == '0 && stepped_q && out_vld_q)
    else $error("step did not clear the counter or flag the result");

  // A register write leaves the pattern at its base.
  a_cfg_rebase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> mask_q == lcgms_pkg::MaskW'(1) && rising_q)
    else $error("register write did not restart the pattern");

  // The input side only stalls behind a full result register that is not taken.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("input stalled without a blocked result");

endmodule

>>> hdl/lcgms_mask_step.sv
// Next chase mask, bounce phase and gate pattern for one step.
`timescale 1ns / 1ps

module lcgms_mask_step (
  input  lcgms_pkg::step_req_t req_i,
  output lcgms_pkg::step_rsp_t rsp_o
);

  logic [lcgms_pkg::RunW-1:0]  run_len;
  logic [lcgms_pkg::MaskW-1:0] top;
  logic [lcgms_pkg::MaskW-1:0] full;
  logic [lcgms_pkg::MaskW-1:0] shl;
  logic [lcgms_pkg::MaskW-1:0] grow;
  logic [lcgms_pkg::MaskW-1:0] half;
  logic [lcgms_pkg::MaskW-1:0] dbl;
  logic [lcgms_pkg::MaskW-1:0] mask_d;
  logic                        rising_d;
  logic [lcgms_pkg::GateW-1:0] gates;

  assign run_len = req_i.triplify ? lcgms_pkg::TripleRun : lcgms_pkg::FullRun;
  assign top     = lcgms_pkg::MaskW'(1) << run_len;
  assign full    = top - lcgms_pkg::MaskW'(1);
  assign half    = top >> 1;
  assign shl     = req_i.mask << 1;
  assign grow    = full & (shl + lcgms_pkg::MaskW'(1));

  // The double dot re-seeds the pair whenever a lone dot reaches bit one.
  always_comb begin
    dbl = (shl == lcgms_pkg::MaskW'(2)) ? lcgms_pkg::MaskW'(3) : shl;
    dbl = dbl & full;
    if (dbl == '0) begin
      dbl = lcgms_pkg::MaskW'(1);
    end
  end

  always_comb begin
    mask_d   = req_i.mask;
    rising_d = req_i.rising;
    unique case (lcgms_pkg::pattern_e'(req_i.mode))
      lcgms_pkg::PatSingle: begin
        mask_d = (shl == top) ? lcgms_pkg::MaskW'(1) : shl;
      end
      lcgms_pkg::PatGrow: begin
        if (req_i.rising) begin
          mask_d   = grow;
          rising_d = (grow != full);
        end else begin
          mask_d   = req_i.mask >> 1;
          rising_d = ((req_i.mask >> 1) == lcgms_pkg::MaskW'(1));
        end
      end
      lcgms_pkg::PatPass: begin
        if (req_i.rising) begin
          mask_d   = grow;
          rising_d = (grow != full);
        end else begin
          mask_d   = shl & full;
          rising_d = ((shl & full) == half);
        end
      end
      lcgms_pkg::PatDouble: begin
        mask_d = dbl;
      end
      default: begin
        mask_d   = req_i.mask;
        rising_d = req_i.rising;
      end
    endcase
  end

  // Gate i follows mask bit (i mod run length); both remainders are fixed per gate.
  always_comb begin
    gates = '0;
    for (int i = 0; i < lcgms_pkg::GateW; i++) begin
      if (i < lcgms_pkg::NumOutputs) begin
        gates[i] = req_i.triplify ? mask_d[i % 3] : mask_d[i % lcgms_pkg::NumOutputs];
      end
    end
  end

  assign rsp_o.mask   = mask_d;
  assign rsp_o.rising = rising_d;
  assign rsp_o.gates  = gates;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the gate mask sequencer: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import lcgms_pkg::*;

  // Cycles without any accepted request before the run is declared hung. The longest
  // legitimate quiet stretch is the receiver's long hold-off plus a long sender gap.
  localparam int unsigned QuietLimit  = 1000;
  // Length of the deliberate receiver hold-off that fills the block and stalls its input.
  localparam int unsigned LongHold    = 60;
  localparam int unsigned PhaseItems  = 115;
  localparam int unsigned NumPhases   = 11;
  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    logic [GateW-1:0] gates;
    logic             stepped;
  } gate_res_t;

  // One row of the directed table: either a register write or a run of identical ticks.
  // Where known_res is set, the expected result is written into the row by hand.
  typedef struct packed {
    bit               wr;
    reg_idx_e         reg_sel;
    logic [DataW-1:0] wdata;
    logic [RateW-1:0] rate;
    logic [4:0]       reps;
    bit               known_res;
    logic [GateW-1:0] gates;
    bit               stepped;
  } tick_row_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  logic [RateW-1:0] rate_value_i = '0;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;
  logic [GateW-1:0] gate_bits_o;
  logic             stepped_o;
  logic             psel         = 1'b0;
  logic             penable      = 1'b0;
  logic             pwrite       = 1'b0;
  logic [AddrW-1:0] paddr        = '0;
  logic [DataW-1:0] pwdata       = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  always #4 clk_i = ~clk_i;

  led_chaser_gate_mask_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rate_value_i(rate_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .gate_bits_o (gate_bits_o),
    .stepped_o   (stepped_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Shadow copy of the sequencer state and its two registers.
  logic [ModeW-1:0] pat_mode;
  logic             trip_on;
  logic [CntW-1:0]  step_cnt;
  logic [MaskW-1:0] chase;
  logic             rising;
  logic [GateW-1:0] gates_held;

  gate_res_t   pending_gates_q[$];
  int unsigned mismatch_cnt = 0;
  // Idling style of the current phase: 0 means none, 1 light, 2 heavy.
  int unsigned idle_level   = 0;
  bit          hold_req     = 1'b0;

  tick_row_t dir_rows [10];

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReported) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Works out the result of one tick and advances the shadow state accordingly.
  function automatic gate_res_t next_gate_result(input logic [RateW-1:0] rate);
    int unsigned      rl;
    logic [MaskW-1:0] top;
    logic [MaskW-1:0] full;
    logic [MaskW-1:0] m;
    gate_res_t        res;
    res.stepped = 1'b0;
    if (pat_mode != PatDisabled) begin
      step_cnt = step_cnt + CntW'(rate >> 2);
      if (step_cnt >= StepLimit) begin
        rl   = trip_on ? TripleRun : FullRun;
        top  = MaskW'(1) << rl;
        full = top - 1'b1;
        m    = chase;
        case (pat_mode)
          PatSingle: begin
            m = m << 1;
            if (m == top) m = MaskW'(1);
          end
          PatGrow: begin
            if (rising) begin
              m = full & ((m << 1) + 1'b1);
              if (m == full) rising = 1'b0;
            end else begin
              m = m >> 1;
              if (m == MaskW'(1)) rising = 1'b1;
            end
          end
          PatPass: begin
            if (rising) begin
              m = full & ((m << 1) + 1'b1);
              if (m == full) rising = 1'b0;
            end else begin
              m = (m << 1) & full;
              if (m == (MaskW'(1) << (rl - 1))) rising = 1'b1;
            end
          end
          PatDouble: begin
            m = m << 1;
            if (m == MaskW'(2)) m = MaskW'(3);
            m = m & full;
            if (m == '0) m = MaskW'(1);
          end
          // Undefined codes keep the mask but still reload the gates below.
          default: ;
        endcase
        chase = m;
        // Only the first GateW outputs carry a gate bit.
        for (int i = 0; i < GateW; i++) gates_held[i] = m[i % rl];
        step_cnt    = '0;
        res.stepped = 1'b1;
      end
    end
    res.gates = gates_held;
    return res;
  endfunction

  // Gap length for either side: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idle_level == 0) return 0;
    if (idle_level == 1) begin
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
    end
    if (r < 30) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Rates lean high so that the mask steps often and the bounce patterns run their
  // full course; the rest cover the whole field, the extremes included.
  function automatic logic [RateW-1:0] pick_rate();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    if (r < 25) return RateW'($urandom_range(0, 1023));
    return RateW'($urandom_range(768, 1023));
  endfunction

  // Offers one tick request, waits for it to be taken, and records what it should give.
  // Returns at a falling edge, with valid already lowered if a gap follows.
  task automatic send_tick(input logic [RateW-1:0] rate, input bit known_res,
                           input gate_res_t hand_res, input int unsigned gap);
    gate_res_t pred;
    in_valid_i   <= 1'b1;
    rate_value_i <= rate;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = next_gate_result(rate);
    pending_gates_q.push_back(known_res ? hand_res : pred);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Stops offering requests and waits until every expected result has been taken, then
  // lets the pipeline settle before anything else happens. Returns at a falling edge.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_gates_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register transfer: setup phase, then access phase until pready.
  task automatic apb_xfer(input bit wr, input reg_idx_e idx, input logic [DataW-1:0] data,
                          output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes a register while the block is idle, mirrors it in the shadow state, and reads
  // it back. Either write sends the pattern back to its base.
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] val);
    logic [DataW-1:0] rd;
    logic [DataW-1:0] want;
    apb_xfer(1'b1, idx, val, rd);
    if (idx == RegPatternMode) begin
      pat_mode = val[ModeW-1:0];
      want     = DataW'(val[ModeW-1:0]);
    end else begin
      trip_on  = val[0];
      want     = DataW'(val[0]);
    end
    chase  = MaskW'(1);
    rising = 1'b1;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== want)
      note_mismatch($sformatf("register %s read back %h, expected %h", idx.name(), rd, want));
  endtask

  // Result side: random stalls, plus the one long hold-off that the stimulus asks for,
  // counted here so that the sender keeps offering requests all the while.
  initial begin
    int unsigned stall_left;
    gate_res_t   want;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = LongHold;
        hold_req   = 1'b0;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_gates_q.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected: gate_bits %h stepped %b",
                                  gate_bits_o, stepped_o));
        end else begin
          want = pending_gates_q.pop_front();
          if (gate_bits_o !== want.gates)
            note_mismatch($sformatf("gate_bits expected %h, got %h", want.gates, gate_bits_o));
          if (stepped_o !== want.stepped)
            note_mismatch($sformatf("stepped expected %b, got %b", want.stepped, stepped_o));
        end
      end
    end
  end

  // Watchdog: ends the run if no request of any kind is taken for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [ModeW-1:0] phase_mode [NumPhases];
    bit               phase_trip [NumPhases];
    logic [DataW-1:0] noise;

    // Shadow state as it stands after reset.
    pat_mode   = PatDisabled;
    trip_on    = 1'b0;
    step_cnt   = '0;
    chase      = MaskW'(1);
    rising     = 1'b1;
    gates_held = '0;

    // Directed part. After reset the pattern is disabled, so nothing moves. Then the
    // single dot is enabled with junk in the upper data bits, and eight full-rate ticks
    // bring the counter to 2040; a rate of 32 adds exactly the last eight, so the limit
    // is hit exactly and the dot moves to output one. A rate of three adds nothing.
    // Triplify and the double dot follow, and finally the pattern is switched off again
    // so that the gates are seen to hold.
    dir_rows = '{
      '{1'b0, RegPatternMode, '0, 10'd1023, 5'd1, 1'b1, 8'h00, 1'b0},
      '{1'b1, RegPatternMode, {28'hFFFF_FFF, PatSingle}, '0, 5'd0, 1'b0, 8'h00, 1'b0},
      '{1'b0, RegPatternMode, '0, 10'd3, 5'd1, 1'b1, 8'h00, 1'b0},
      '{1'b0, RegPatternMode, '0, 10'd1023, 5'd8, 1'b1, 8'h00, 1'b0},
      '{1'b0, RegPatternMode, '0, 10'd32, 5'd1, 1'b1, 8'h02, 1'b1},
      '{1'b1, RegTriplify, 32'hAAAA_5555, '0, 5'd0, 1'b0, 8'h00, 1'b0},
      '{1'b1, RegPatternMode, {28'h0, PatDouble}, '0, 5'd0, 1'b0, 8'h00, 1'b0},
      '{1'b0, RegPatternMode, '0, 10'd1023, 5'd9, 1'b0, 8'h00, 1'b0},
      '{1'b1, RegPatternMode, {28'h5555_AAA, PatDisabled}, '0, 5'd0, 1'b0, 8'h00, 1'b0},
      '{1'b0, RegPatternMode, '0, 10'd1023, 5'd2, 1'b0, 8'h00, 1'b0}
    };

    // Random phases: single dot, grow and pass in both run lengths, double dot in the
    // full run, the highest and another undefined code, disabled, fully random last.
    phase_mode = '{PatSingle, PatGrow, PatPass, PatDouble, PatGrow, PatPass, PatSingle,
                   {ModeW{1'b1}}, ModeW'($urandom_range(5, 14)), PatDisabled,
                   ModeW'($urandom_range(0, 15))};
    phase_trip = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
                   1'($urandom_range(0, 1))};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_level = 1;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].wr) begin
        drain_block();
        write_reg(dir_rows[r].reg_sel, dir_rows[r].wdata);
      end else begin
        repeat (dir_rows[r].reps)
          send_tick(dir_rows[r].rate, dir_rows[r].known_res,
                    '{dir_rows[r].gates, dir_rows[r].stepped}, pick_gap());
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_block();
      // Phases rotate between no idling, light idling and heavy idling.
      idle_level = p % 3;
      noise = $urandom();
      if (noise[0]) begin
        write_reg(RegPatternMode, {noise[DataW-1:ModeW], phase_mode[p]});
        write_reg(RegTriplify, {noise[DataW-2:0], phase_trip[p]});
      end else begin
        write_reg(RegTriplify, {noise[DataW-2:0], phase_trip[p]});
        write_reg(RegPatternMode, {noise[DataW-1:ModeW], phase_mode[p]});
      end
      for (int n = 0; n < PhaseItems; n++) begin
        // The receiver holds off for a long stretch while ticks keep coming, so the
        // block fills up and has to stall its input.
        if (p == 1 && n == 40) hold_req = 1'b1;
        // The sender pauses mid-phase until every outstanding result has come back.
        if (p == 4 && n == 50) drain_block();
        send_tick(pick_rate(), 1'b0, '0, pick_gap());
      end
    end

    drain_block();
    repeat (8) @(posedge clk_i);
    mismatch_cnt += pending_gates_q.size();
    if (mismatch_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
hdl/lcgms_pkg.sv
hdl/lcgms_mask_step.sv
hdl/led_chaser_gate_mask_sequencer.sv
tb/tb_top.sv
